// ===== rtl/sfr_pkg.sv =====
// Shared widths, codes and types of the SPI slave frame receiver.
package sfr_pkg;

	localparam int RX_FRAME_LEN_DEF = 39;
	localparam int TX_FRAME_LEN_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 6;
	localparam int IDX_W    = 8;
	localparam int STATUS_W = 2;
	localparam int ERR_W    = 8;
	localparam int TOTAL_W  = 16;
	localparam int SUM_W    = 16;

	localparam logic [MODE_W-1:0] MODE_EXCHANGE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ     = 2'd3;

	localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERRUN  = 2'd2;

	localparam logic [BYTE_W-1:0] START_MARK     = 8'h3C;
	localparam logic [BYTE_W-1:0] END_MARK       = 8'h3E;
	localparam logic [BYTE_W-1:0] REPLY_IDLE     = 8'hFF;
	localparam logic [BYTE_W-1:0] REPLY_PAST_END = 8'hAA;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
	} sfr_wr_t;

	typedef struct packed {
		logic                active;
		logic                complete;
		logic                sum_ok;
		logic [STATUS_W-1:0] status;
		logic [ERR_W-1:0]    err_cnt;
		logic [TOTAL_W-1:0]  total;
		logic [IDX_W-1:0]    idx;
	} sfr_state_t;

endpackage

// ===== rtl/sfr_in_if.sv =====
// Request channel: one mode, data byte and address per request.
interface sfr_in_if;
	logic                          valid;
	logic                          ready;
	logic [sfr_pkg::MODE_W-1:0]    mode;
	logic [sfr_pkg::BYTE_W-1:0]    data_byte;
	logic [sfr_pkg::ADDR_W-1:0]    address;

	modport source(output valid, mode, data_byte, address, input ready);
	modport sink(input valid, mode, data_byte, address, output ready);
endinterface

// ===== rtl/sfr_out_if.sv =====
// Result channel: reply byte, read byte and frame status per request.
interface sfr_out_if;
	logic                           valid;
	logic                           ready;
	logic [sfr_pkg::BYTE_W-1:0]     reply_byte;
	logic [sfr_pkg::BYTE_W-1:0]     read_byte;
	logic                           frame_done;
	logic                           checksum_ok;
	logic [sfr_pkg::STATUS_W-1:0]   status;
	logic                           receiving;
	logic [sfr_pkg::ERR_W-1:0]      check_error_count;
	logic [sfr_pkg::TOTAL_W-1:0]    stored_byte_count;

	modport source(output valid, reply_byte, read_byte, frame_done, checksum_ok, status,
		receiving, check_error_count, stored_byte_count, input ready);
	modport sink(input valid, reply_byte, read_byte, frame_done, checksum_ok, status,
		receiving, check_error_count, stored_byte_count, output ready);
endinterface

// ===== rtl/sfr_frame_ctl.sv =====
// Frame state machine: markers, byte index, overrun, running checksum and counters.
module sfr_frame_ctl #(
	parameter int RX_FRAME_LEN = sfr_pkg::RX_FRAME_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [sfr_pkg::MODE_W-1:0]  mode,
	input  logic [sfr_pkg::BYTE_W-1:0]  data_byte,
	output sfr_pkg::sfr_state_t         nxt,
	output sfr_pkg::sfr_wr_t            wr
);
	import sfr_pkg::*;

	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(RX_FRAME_LEN - 2);
	localparam logic [IDX_W-1:0] IDX_HI  = IDX_W'(RX_FRAME_LEN - 4);
	localparam logic [IDX_W-1:0] IDX_LO  = IDX_W'(RX_FRAME_LEN - 3);

	sfr_state_t        cur_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BYTE_W-1:0] hi_q;
	logic [BYTE_W-1:0] lo_q;

	logic [SUM_W-1:0]  sum_d;
	logic [BYTE_W-1:0] hi_d;
	logic [BYTE_W-1:0] lo_d;
	sfr_wr_t           wr_d;

	always_comb begin
		nxt   = cur_q;
		sum_d = sum_q;
		hi_d  = hi_q;
		lo_d  = lo_q;
		wr_d  = '0;
		case (mode)
			MODE_EXCHANGE: begin
				if (data_byte == END_MARK && cur_q.active && cur_q.idx == IDX_END) begin
					nxt.active   = 1'b0;
					nxt.complete = 1'b1;
					nxt.status   = ST_COMPLETE;
					nxt.sum_ok   = (sum_q == {hi_q, lo_q});
					if (sum_q != {hi_q, lo_q}) begin
						nxt.err_cnt = cur_q.err_cnt + 1'b1;
					end
				end
				// Overrun depends on the index alone, so it keeps firing until a new start.
				if (cur_q.idx > IDX_END) begin
					nxt.active = 1'b0;
					nxt.status = ST_OVERRUN;
				end
				if (nxt.active) begin
					wr_d.we   = 1'b1;
					wr_d.idx  = cur_q.idx;
					wr_d.data = data_byte;
					nxt.idx   = cur_q.idx + 1'b1;
					nxt.total = cur_q.total + 1'b1;
					if (cur_q.idx < IDX_HI) begin
						sum_d = sum_q + SUM_W'(data_byte);
					end else if (cur_q.idx == IDX_HI) begin
						hi_d = data_byte;
					end else if (cur_q.idx == IDX_LO) begin
						lo_d = data_byte;
					end
				end
				if (data_byte == START_MARK && !nxt.active && !nxt.complete) begin
					nxt.active = 1'b1;
					nxt.idx    = '0;
					sum_d      = '0;
				end
			end
			MODE_ACK: begin
				nxt.complete = 1'b0;
				nxt.status   = ST_NONE;
			end
			default: begin
			end
		endcase
		wr    = wr_d;
		wr.we = wr_d.we & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			cur_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= sum_d;
			hi_q  <= hi_d;
			lo_q  <= lo_d;
		end
	end

endmodule

// ===== rtl/sfr_reply_buf.sv =====
// Reply byte buffer loaded by the host, with the reply selection for the next exchange.
module sfr_reply_buf #(
	parameter int TX_FRAME_LEN = sfr_pkg::TX_FRAME_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [sfr_pkg::ADDR_W-1:0]  address,
	input  logic [sfr_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        active,
	input  logic [sfr_pkg::IDX_W-1:0]   idx,
	output logic [sfr_pkg::BYTE_W-1:0]  reply_byte
);
	import sfr_pkg::*;

	localparam int TW = $clog2(TX_FRAME_LEN);

	logic [BYTE_W-1:0] buf_q [TX_FRAME_LEN];
	logic              load_ok;
	logic [TW-1:0]     waddr;
	logic [TW-1:0]     raddr;

	assign load_ok = load && (int'(address) < TX_FRAME_LEN);
	assign waddr   = TW'(address);
	assign raddr   = TW'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TX_FRAME_LEN; i++) begin
				buf_q[i] <= '0;
			end
		end else if (load_ok) begin
			buf_q[waddr] <= data_byte;
		end
	end

	// A load at the index being replied from shows up in the same result.
	always_comb begin
		if (!active) begin
			reply_byte = REPLY_IDLE;
		end else if (int'(idx) >= TX_FRAME_LEN) begin
			reply_byte = REPLY_PAST_END;
		end else if (load_ok && waddr == raddr) begin
			reply_byte = data_byte;
		end else begin
			reply_byte = buf_q[raddr];
		end
	end

endmodule

// ===== rtl/sfr_rx_ram.sv =====
// Receive byte memory, written by the frame logic and read by host read requests.
module sfr_rx_ram #(
	parameter int RX_FRAME_LEN = sfr_pkg::RX_FRAME_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [sfr_pkg::MODE_W-1:0]  mode,
	input  logic [sfr_pkg::ADDR_W-1:0]  address,
	input  sfr_pkg::sfr_wr_t            wr,
	output logic [sfr_pkg::BYTE_W-1:0]  read_byte
);
	import sfr_pkg::*;

	localparam int RW = $clog2(RX_FRAME_LEN);

	logic [BYTE_W-1:0] mem [RX_FRAME_LEN];
	logic [BYTE_W-1:0] rd_q;
	logic              rd_ok_q;
	logic              rd_ok;

	assign rd_ok = (mode == MODE_READ) && (int'(address) < RX_FRAME_LEN);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[RW'(wr.idx)] <= wr.data;
		end
		if (accept && rd_ok) begin
			rd_q <= mem[RW'(address)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (accept) begin
			rd_ok_q <= rd_ok;
		end
	end

	assign read_byte = rd_ok_q ? rd_q : '0;

endmodule

// ===== rtl/spi_slave_frame_receiver.sv =====
// Top level of the SPI slave frame receiver.
// Each request on req carries a mode: a byte exchanged with the SPI master, a frame
// acknowledge, a reply byte load at an address, or a read of a received byte.
// A '<' byte opens a frame; the following bytes are stored, and '>' closes the frame
// once exactly RX_FRAME_LEN-2 bytes are held. The 16-bit sum of the payload is then
// checked against the big-endian pair behind it; failures are counted.
// Every request gives one result on res: the reply byte for the next exchange, the
// read byte, and the frame status and counters after the request.
// A request's result is registered at the edge that accepts it and is valid from that
// edge on. One request is taken every cycle while res does not stall; the state update
// is a single pass of logic between the state registers and the result register.
// When res stalls, the result register holds and req is not ready; req becomes ready
// again in the cycle the result is taken, so a new request enters in the same cycle.
// Reset clears the frame state, counters and reply bytes; the receive memory is not
// cleared and needs no clearing pass.
module spi_slave_frame_receiver #(
	parameter int RX_FRAME_LEN = sfr_pkg::RX_FRAME_LEN_DEF,
	parameter int TX_FRAME_LEN = sfr_pkg::TX_FRAME_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sfr_in_if.sink    req,
	sfr_out_if.source res
);
	import sfr_pkg::*;

	logic              accept;
	sfr_state_t        nxt;
	sfr_wr_t           wr;
	logic [BYTE_W-1:0] reply_d;
	logic [BYTE_W-1:0] read_byte;

	logic              valid_q;
	sfr_state_t        res_q;
	logic [BYTE_W-1:0] reply_q;

	assign req.ready = !valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	sfr_frame_ctl #(
		.RX_FRAME_LEN(RX_FRAME_LEN)
	) u_frame_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (req.mode),
		.data_byte(req.data_byte),
		.nxt      (nxt),
		.wr       (wr)
	);

	sfr_reply_buf #(
		.TX_FRAME_LEN(TX_FRAME_LEN)
	) u_reply_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && req.mode == MODE_LOAD),
		.address   (req.address),
		.data_byte (req.data_byte),
		.active    (nxt.active),
		.idx       (nxt.idx),
		.reply_byte(reply_d)
	);

	sfr_rx_ram #(
		.RX_FRAME_LEN(RX_FRAME_LEN)
	) u_rx_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (req.mode),
		.address  (req.address),
		.wr       (wr),
		.read_byte(read_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.ready) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q   <= nxt;
			reply_q <= reply_d;
		end
	end

	assign res.valid             = valid_q;
	assign res.reply_byte        = reply_q;
	assign res.read_byte         = read_byte;
	assign res.frame_done        = res_q.complete;
	assign res.checksum_ok       = res_q.sum_ok;
	assign res.status            = res_q.status;
	assign res.receiving         = res_q.active;
	assign res.check_error_count = res_q.err_cnt;
	assign res.stored_byte_count = res_q.total;

endmodule

// ===== verif/sfr_frame_checker.sv =====
// Result checker for the SPI slave frame receiver: predicts each result and compares it.
module sfr_frame_checker #(
	parameter int RX_LEN = sfr_pkg::RX_FRAME_LEN_DEF,
	parameter int TX_LEN = sfr_pkg::TX_FRAME_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sfr_in_if                 req,
	sfr_out_if                res,
	output int                errors,
	output int                pending,
	output logic [RX_LEN-1:0] rx_written
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfr_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0]   reply;
		logic [BYTE_W-1:0]   rd;
		logic                done;
		logic                sum_ok;
		logic [STATUS_W-1:0] status;
		logic                recv;
		logic [ERR_W-1:0]    errs;
		logic [TOTAL_W-1:0]  total;
	} frame_result_t;

	frame_result_t expected_q[$];

	logic                rx_active;
	logic                rx_complete;
	logic [IDX_W-1:0]    rx_idx;
	logic [STATUS_W-1:0] rx_status;
	logic [TOTAL_W-1:0]  stored_total;
	logic [ERR_W-1:0]    fail_count;
	logic                sum_match;
	logic [BYTE_W-1:0]   rx_buf[RX_LEN];
	logic [BYTE_W-1:0]   tx_buf[TX_LEN];

	function automatic frame_result_t step_frame(input logic [MODE_W-1:0] m,
			input logic [BYTE_W-1:0] d, input logic [ADDR_W-1:0] a);
		frame_result_t r;
		logic [SUM_W-1:0] payload_sum;
		logic [SUM_W-1:0] pair_value;
		r = '0;
		case (m)
			MODE_EXCHANGE: begin
				if (d == END_MARK && rx_active && rx_idx == IDX_W'(RX_LEN - 2)) begin
					rx_active   = 1'b0;
					rx_complete = 1'b1;
					rx_status   = ST_COMPLETE;
					payload_sum = '0;
					for (int i = 0; i < RX_LEN - 4; i++)
						payload_sum += SUM_W'(rx_buf[i]);
					pair_value = {rx_buf[RX_LEN-4], rx_buf[RX_LEN-3]};
					sum_match  = (payload_sum == pair_value);
					if (!sum_match)
						fail_count++;
				end
				// The overrun test runs before the start marker test, so one byte
				// may both report the overrun and open the next frame.
				if (rx_idx > IDX_W'(RX_LEN - 2)) begin
					rx_active = 1'b0;
					rx_status = ST_OVERRUN;
				end
				if (rx_active) begin
					if (rx_idx < RX_LEN) begin
						rx_buf[rx_idx]     = d;
						rx_written[rx_idx] = 1'b1;
					end
					rx_idx++;
					stored_total++;
				end
				if (d == START_MARK && !rx_active && !rx_complete) begin
					rx_active = 1'b1;
					rx_idx    = '0;
				end
			end
			MODE_ACK: begin
				rx_complete = 1'b0;
				rx_status   = ST_NONE;
			end
			MODE_LOAD: begin
				if (a < TX_LEN)
					tx_buf[a] = d;
			end
			default: begin
				if (a < RX_LEN)
					r.rd = rx_buf[a];
			end
		endcase
		if (!rx_active)
			r.reply = REPLY_IDLE;
		else if (rx_idx < TX_LEN)
			r.reply = tx_buf[rx_idx];
		else
			r.reply = REPLY_PAST_END;
		r.done   = rx_complete;
		r.sum_ok = sum_match;
		r.status = rx_status;
		r.recv   = rx_active;
		r.errs   = fail_count;
		r.total  = stored_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		frame_result_t want;
		if (!arst_n) begin
			rx_active    = 1'b0;
			rx_complete  = 1'b0;
			rx_idx       = '0;
			rx_status    = ST_NONE;
			stored_total = '0;
			fail_count   = '0;
			sum_match    = 1'b0;
			rx_written   = '0;
			for (int i = 0; i < TX_LEN; i++)
				tx_buf[i] = '0;
			expected_q.delete();
			pending = 0;
			errors  = 0;
		end else begin
			if (req.valid && req.ready)
				expected_q.push_back(step_frame(req.mode, req.data_byte, req.address));
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$error("result arrived with no request outstanding");
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("reply_byte", 16'(want.reply), 16'(res.reply_byte));
					check_field("read_byte", 16'(want.rd), 16'(res.read_byte));
					check_field("frame_done", 16'(want.done), 16'(res.frame_done));
					check_field("checksum_ok", 16'(want.sum_ok), 16'(res.checksum_ok));
					check_field("status", 16'(want.status), 16'(res.status));
					check_field("receiving", 16'(want.recv), 16'(res.receiving));
					check_field("check_error_count", 16'(want.errs),
						16'(res.check_error_count));
					check_field("stored_byte_count", want.total, res.stored_byte_count);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfr_pkg::*;

	localparam int RX_LEN      = RX_FRAME_LEN_DEF;
	localparam int TX_LEN      = TX_FRAME_LEN_DEF;
	localparam int PAYLOAD_LEN = RX_LEN - 4;
	localparam int ITEM_TARGET = 1350;
	localparam int IDLE_LIMIT  = 2000;
	localparam int ADDR_MAX    = 2**ADDR_W - 1;

	logic              clk;
	logic              arst_n;
	int                errors;
	int                pending;
	logic [RX_LEN-1:0] rx_written;
	int                sent;
	int                idle_cycles = 0;
	int                stall_left;
	bit                steady;
	bit                drained;
	int                pick;

	sfr_in_if  req_if();
	sfr_out_if res_if();

	spi_slave_frame_receiver #(
		.RX_FRAME_LEN(RX_LEN),
		.TX_FRAME_LEN(TX_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if)
	);

	sfr_frame_checker #(
		.RX_LEN(RX_LEN),
		.TX_LEN(TX_LEN)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if),
		.errors(errors),
		.pending(pending),
		.rx_written(rx_written)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none during a steady stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Entries that were never stored are not read; such picks move out of range.
	function automatic logic [ADDR_W-1:0] read_addr();
		logic [ADDR_W-1:0] a;
		a = ADDR_W'($urandom_range(0, ADDR_MAX));
		if (a < RX_LEN && !rx_written[a])
			a = ADDR_W'($urandom_range(RX_LEN, ADDR_MAX));
		return a;
	endfunction

	// Entered and left at a falling edge; valid stays high when the next request follows.
	task automatic send(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d,
			input logic [ADDR_W-1:0] a);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.mode      <= m;
		req_if.data_byte <= d;
		req_if.address   <= a;
		do @(posedge clk); while (!req_if.ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic send_side_request();
		if ($urandom_range(0, 1))
			send(MODE_LOAD, BYTE_W'($urandom), ADDR_W'($urandom_range(0, TX_LEN + 3)));
		else
			send(MODE_READ, BYTE_W'($urandom), read_addr());
	endtask

	task automatic send_noise();
		logic [MODE_W-1:0] m;
		m = MODE_W'($urandom);
		if (m == MODE_READ)
			send(m, BYTE_W'($urandom), read_addr());
		else
			send(m, BYTE_W'($urandom), ADDR_W'($urandom));
	endtask

	task automatic send_frame(input bit good_sum, input bit chatty);
		logic [BYTE_W-1:0] b;
		logic [SUM_W-1:0]  payload_sum;
		logic [SUM_W-1:0]  pair_value;
		payload_sum = '0;
		send(MODE_EXCHANGE, START_MARK, ADDR_W'($urandom));
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			b = BYTE_W'($urandom);
			payload_sum += SUM_W'(b);
			send(MODE_EXCHANGE, b, ADDR_W'($urandom));
			if (chatty && $urandom_range(0, 9) == 0)
				send_side_request();
		end
		if (good_sum)
			pair_value = payload_sum;
		else
			pair_value = payload_sum ^ SUM_W'($urandom_range(1, 65535));
		send(MODE_EXCHANGE, pair_value[15:8], ADDR_W'($urandom));
		send(MODE_EXCHANGE, pair_value[7:0], ADDR_W'($urandom));
		send(MODE_EXCHANGE, END_MARK, ADDR_W'($urandom));
	endtask

	// Too many bytes without an end marker; the last may carry a start marker.
	task automatic send_overrun(input bit reopen);
		logic [BYTE_W-1:0] b;
		int n;
		n = RX_LEN + $urandom_range(0, 2);
		send(MODE_EXCHANGE, START_MARK, ADDR_W'($urandom));
		for (int i = 0; i < n; i++) begin
			do b = BYTE_W'($urandom); while (b == END_MARK);
			if (reopen && i == n - 1)
				b = START_MARK;
			send(MODE_EXCHANGE, b, ADDR_W'($urandom));
		end
	endtask

	task automatic send_early_end();
		send(MODE_EXCHANGE, START_MARK, ADDR_W'($urandom));
		repeat ($urandom_range(0, 10))
			send(MODE_EXCHANGE, BYTE_W'($urandom), ADDR_W'($urandom));
		send(MODE_EXCHANGE, END_MARK, ADDR_W'($urandom));
	endtask

	initial begin
		res_if.ready = 1'b0;
		stall_left   = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.mode      = MODE_EXCHANGE;
		req_if.data_byte = '0;
		req_if.address   = '0;
		steady           = 1'b0;
		drained          = 1'b0;
		sent             = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Out-of-range reads and loads, field extremes, markers while idle.
		send(MODE_READ, 8'h00, ADDR_W'(ADDR_MAX));
		send(MODE_READ, 8'hFF, ADDR_W'(RX_LEN));
		send(MODE_ACK, 8'hFF, '0);
		send(MODE_LOAD, 8'hFF, '0);
		send(MODE_LOAD, 8'h00, ADDR_W'(TX_LEN - 1));
		send(MODE_LOAD, 8'h5A, ADDR_W'(TX_LEN));
		send(MODE_LOAD, 8'hA5, ADDR_W'(ADDR_MAX));
		send(MODE_EXCHANGE, 8'h00, ADDR_W'(ADDR_MAX));
		send(MODE_EXCHANGE, 8'hFF, '0);
		send(MODE_EXCHANGE, END_MARK, '0);
		// Inside a frame an early end marker and a second start marker are data.
		send(MODE_EXCHANGE, START_MARK, '0);
		send(MODE_EXCHANGE, END_MARK, '0);
		send(MODE_EXCHANGE, START_MARK, '0);
		send(MODE_READ, 8'h00, ADDR_W'(0));
		send(MODE_READ, 8'h00, ADDR_W'(1));
		send(MODE_ACK, 8'h00, ADDR_W'(ADDR_MAX));
		// Overrun clears the open frame; then a good frame, a start marker while
		// it waits, and a frame with a bad checksum.
		send_overrun(1'b1);
		send_overrun(1'b0);
		send_frame(1'b1, 1'b0);
		send(MODE_EXCHANGE, START_MARK, '0);
		send(MODE_EXCHANGE, 8'h11, '0);
		send(MODE_ACK, 8'h00, '0);
		send_frame(1'b0, 1'b0);
		send(MODE_ACK, 8'h00, '0);

		while (sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 99) < 15);
			if (!drained && sent > ITEM_TARGET / 2) begin
				drain();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_frame(pick < 35, $urandom_range(0, 1));
				if ($urandom_range(0, 4) != 0)
					send(MODE_ACK, BYTE_W'($urandom), ADDR_W'($urandom));
			end else if (pick < 62) begin
				send_overrun(pick < 56);
			end else if (pick < 70) begin
				send_early_end();
			end else if (pick < 75) begin
				send(MODE_ACK, BYTE_W'($urandom), ADDR_W'($urandom));
			end else if (pick < 85) begin
				send_side_request();
			end else begin
				send_noise();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sfr_pkg.sv
rtl/sfr_in_if.sv
rtl/sfr_out_if.sv
rtl/sfr_frame_ctl.sv
rtl/sfr_reply_buf.sv
rtl/sfr_rx_ram.sv
rtl/spi_slave_frame_receiver.sv
verif/sfr_frame_checker.sv
verif/tb.sv
